// ===== design/ltb_pkg.sv =====
// Shared types and codes for the line table edit buffer.
package ltb_pkg;

	localparam int LINE_W = 16;
	localparam int VAL_W  = 32;
	localparam int HOLD_W = 11;

	typedef enum logic [1:0] {
		ACT_WRITE  = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_PRINT  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [LINE_W-1:0] first_line;
		logic [LINE_W-1:0] last_line;
		logic [VAL_W-1:0]  row_handle;
	} in_word_t;

	typedef struct packed {
		logic [VAL_W-1:0]  line_value;
		logic              present;
		logic [HOLD_W-1:0] lines_held;
		logic [1:0]        status;
		logic              last;
	} out_word_t;

endpackage

// ===== design/ltb_chan_if.sv =====
// Valid/ready channel carrying one word of type T.
interface ltb_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ltb_store.sv =====
// Line handle memory: one write port, one read port with registered data.
module ltb_store #(
	parameter int AW = 10,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== design/ltb_alu.sv =====
// Shared cursor step unit: next cursor and end-of-run compare.
module ltb_alu #(
	parameter int NW = 17
) (
	input  logic [NW-1:0] cur,
	input  logic [NW-1:0] lim,
	output logic [NW-1:0] nxt,
	output logic          hit
);
	assign nxt = cur + NW'(1);
	assign hit = (cur == lim);
endmodule

// ===== design/line_table_edit_buffer_core.sv =====
// Line table edit buffer: top level with sequencer, line store and step unit.
//
// Channels: req (sink) takes one word per item: action, first_line, last_line,
// row_handle. rsp (source) gives result words: line_value, present,
// lines_held, status, last. A word moves when valid and ready are both high.
// The block works on one item at a time; req.ready is high only while idle.
// Sequence: a write, a refused item or a delete with no lines after the range
// goes from decode to the response state and then into the output register;
// the next request word is taken once the sequencer is back in idle. A delete
// that moves lines runs the move state, one line moved per cycle through the
// single-port-read line store, then a drain state, then the response state.
// A print reads the store, then loads the output register, for each word, up
// to PRINT_MAX words.
// Results sit in an output register; a new word loads when the register is
// empty or being taken, so a stalled receiver holds the sequencer in place.
// Reset clears the line count and the control state; the line store is not
// cleared and needs no clearing pass, since only written lines are read.
module line_table_edit_buffer_core #(
	parameter int MAX_LINES   = 1024,
	parameter int PRINT_MAX   = 64,
	parameter int HANDLE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	ltb_chan_if.sink    req,
	ltb_chan_if.source  rsp
);
	import ltb_pkg::*;

	localparam int CNT_W = $clog2(MAX_LINES + 1);
	localparam int AW    = $clog2(MAX_LINES);
	localparam int NW    = ((CNT_W > LINE_W) ? CNT_W : LINE_W) + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_DEL_RUN, S_DEL_DRAIN, S_PRN_RD, S_PRN_OUT, S_RESP
	} state_t;

	state_t                 state_q;
	logic [1:0]             act_q;
	logic [NW-1:0]          first_q, last_q;
	logic [HANDLE_BITS-1:0] hdl_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [NW-1:0]          cur_q, lim_q;
	logic [AW-1:0]          dst_q, pend_addr_q;
	logic                   pend_q, pres_q;
	status_t                st_q;
	out_word_t              out_q;
	logic                   ovalid_q;

	logic [NW-1:0]          c, lo, hi, del_n, del_cnt, prn_end;
	logic                   full, wr_append, del_rev, del_none, prn_pres;
	logic [AW-1:0]          wr_addr;
	logic                   out_free, out_load;

	logic                   mem_we, mem_re;
	logic [AW-1:0]          mem_waddr, mem_raddr;
	logic [HANDLE_BITS-1:0] mem_wdata, mem_rdata;

	logic [NW-1:0]          alu_nxt;
	logic                   alu_hit;

	ltb_alu #(.NW(NW)) u_alu (
		.cur (cur_q),
		.lim (lim_q),
		.nxt (alu_nxt),
		.hit (alu_hit)
	);

	ltb_store #(.AW(AW), .DW(HANDLE_BITS)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		c         = NW'(cnt_q);
		full      = (cnt_q >= CNT_W'(MAX_LINES));
		wr_append = (first_q > c);
		wr_addr   = wr_append ? AW'(cnt_q) : AW'(first_q - NW'(1));
		del_rev   = (first_q > last_q);
		del_none  = (c == '0) || (first_q > c) || (last_q == '0);
		lo        = (first_q == '0) ? NW'(1) : first_q;
		hi        = (last_q > c) ? c : last_q;
		del_n     = hi - lo + NW'(1);
		del_cnt   = c - del_n;
		prn_end   = ((last_q - first_q) > NW'(PRINT_MAX - 1)) ?
		            first_q + NW'(PRINT_MAX - 1) : last_q;
		prn_pres  = (cur_q != '0) && (cur_q <= c);
	end

	assign out_free = !ovalid_q || rsp.ready;
	assign out_load = out_free && (state_q == S_PRN_OUT || state_q == S_RESP);

	assign mem_we    = pend_q || (state_q == S_DECODE && act_q == ACT_WRITE &&
	                   first_q != '0 && !full);
	assign mem_waddr = pend_q ? pend_addr_q : wr_addr;
	assign mem_wdata = pend_q ? mem_rdata : hdl_q;
	assign mem_re    = (state_q == S_DEL_RUN) || (state_q == S_PRN_RD && prn_pres);
	assign mem_raddr = (state_q == S_PRN_RD) ? AW'(cur_q - NW'(1)) : AW'(cur_q);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = ovalid_q;
	assign rsp.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			pend_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						act_q   <= req.data.action;
						first_q <= NW'(req.data.first_line);
						last_q  <= NW'(req.data.last_line);
						hdl_q   <= HANDLE_BITS'(req.data.row_handle);
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (act_q)
						ACT_WRITE: begin
							state_q <= S_RESP;
							if (first_q == '0) begin
								st_q <= ST_BAD;
							end else if (full) begin
								st_q <= ST_FULL;
							end else begin
								st_q <= ST_OK;
								if (wr_append) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
						end
						ACT_DELETE: begin
							if (del_rev) begin
								st_q    <= ST_BAD;
								state_q <= S_RESP;
							end else begin
								st_q <= ST_OK;
								if (!del_none) begin
									cnt_q <= CNT_W'(del_cnt);
								end
								if (!del_none && hi < c) begin
									cur_q   <= hi;
									lim_q   <= c - NW'(1);
									dst_q   <= AW'(lo - NW'(1));
									state_q <= S_DEL_RUN;
								end else begin
									state_q <= S_RESP;
								end
							end
						end
						ACT_PRINT: begin
							if (del_rev) begin
								st_q    <= ST_BAD;
								state_q <= S_RESP;
							end else begin
								cur_q   <= first_q;
								lim_q   <= prn_end;
								state_q <= S_PRN_RD;
							end
						end
						default: begin
							st_q    <= ST_BAD;
							state_q <= S_RESP;
						end
					endcase
				end
				S_DEL_RUN: begin
					pend_q      <= 1'b1;
					pend_addr_q <= dst_q;
					dst_q       <= dst_q + AW'(1);
					cur_q       <= alu_nxt;
					if (alu_hit) begin
						state_q <= S_DEL_DRAIN;
					end
				end
				S_DEL_DRAIN: begin
					pend_q  <= 1'b0;
					state_q <= S_RESP;
				end
				S_PRN_RD: begin
					pres_q  <= prn_pres;
					state_q <= S_PRN_OUT;
				end
				S_PRN_OUT: begin
					if (out_free) begin
						out_q.line_value <= pres_q ? VAL_W'(mem_rdata) : '0;
						out_q.present    <= pres_q;
						out_q.lines_held <= HOLD_W'(cnt_q);
						out_q.status     <= ST_OK;
						out_q.last       <= alu_hit;
						cur_q            <= alu_nxt;
						state_q          <= alu_hit ? S_IDLE : S_PRN_RD;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_q.line_value <= '0;
						out_q.present    <= 1'b0;
						out_q.lines_held <= HOLD_W'(cnt_q);
						out_q.status     <= st_q;
						out_q.last       <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_LINES))
		else $error("line count above table size");

	a_present_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.present |-> rsp.data.status == ST_OK)
		else $error("present line with error status");

	a_pend_in_delete: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == S_DEL_RUN || state_q == S_DEL_DRAIN))
		else $error("line move outside delete");

	a_cnt_from_decode: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> $past(state_q) == S_DECODE)
		else $error("line count changed outside decode");
endmodule

// ===== test/line_table_edit_buffer_core_tb.sv =====
// Testbench for the line table edit buffer: random and directed edits checked against a predictor.
module line_table_edit_buffer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ltb_pkg::*;

	localparam int MAX_LINES     = 1024;
	localparam int PRINT_MAX     = 64;
	localparam int HANDLE_BITS   = 32;
	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int RAND_ITEMS    = 405;
	localparam int HOLD_AT       = 340;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 16;

	class line_table_scoreboard;
		logic [VAL_W-1:0] line_tab [MAX_LINES];
		int unsigned line_cnt;
		out_word_t expected_q [$];
		int unsigned fail_cnt;

		function new();
			line_cnt = 0;
			fail_cnt = 0;
		endfunction

		function void push_word(logic [VAL_W-1:0] value, logic pres, logic [1:0] st, logic fin);
			out_word_t w;
			w.line_value = value;
			w.present    = pres;
			w.lines_held = HOLD_W'(line_cnt);
			w.status     = st;
			w.last       = fin;
			expected_q.push_back(w);
		endfunction

		// Applies one accepted request word to the line table and queues its results.
		function void note_request(in_word_t w);
			int unsigned first, lastl, lo, hi, span, ln, i;
			first = 32'(w.first_line);
			lastl = 32'(w.last_line);
			case (w.action)
				ACT_WRITE: begin
					if (first == 0) begin
						push_word('0, 1'b0, ST_BAD, 1'b1);
					end else if (line_cnt >= MAX_LINES) begin
						push_word('0, 1'b0, ST_FULL, 1'b1);
					end else begin
						if (first <= line_cnt) begin
							line_tab[first-1] = w.row_handle;
						end else begin
							line_tab[line_cnt] = w.row_handle;
							line_cnt++;
						end
						push_word('0, 1'b0, ST_OK, 1'b1);
					end
				end
				ACT_DELETE: begin
					if (first > lastl) begin
						push_word('0, 1'b0, ST_BAD, 1'b1);
					end else begin
						if (line_cnt != 0 && first <= line_cnt && lastl >= 1) begin
							lo = (first < 1) ? 1 : first;
							hi = (lastl > line_cnt) ? line_cnt : lastl;
							for (i = hi; i < line_cnt; i++)
								line_tab[lo-1+i-hi] = line_tab[i];
							line_cnt -= hi - lo + 1;
						end
						push_word('0, 1'b0, ST_OK, 1'b1);
					end
				end
				ACT_PRINT: begin
					if (first > lastl) begin
						push_word('0, 1'b0, ST_BAD, 1'b1);
					end else begin
						span = lastl - first + 1;
						if (span > PRINT_MAX)
							span = PRINT_MAX;
						for (i = 0; i < span; i++) begin
							ln = first + i;
							if (ln >= 1 && ln <= line_cnt)
								push_word(line_tab[ln-1], 1'b1, ST_OK, i + 1 == span);
							else
								push_word('0, 1'b0, ST_OK, i + 1 == span);
						end
					end
				end
				default: begin
					push_word('0, 1'b0, ST_BAD, 1'b1);
				end
			endcase
		endfunction

		function void check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				fail_cnt++;
			end
		endfunction

		function void check_response(out_word_t got);
			out_word_t want;
			if (expected_q.size() == 0) begin
				$error("result word with nothing pending: %p", got);
				fail_cnt++;
				return;
			end
			want = expected_q.pop_front();
			check_field("line_value", want.line_value, got.line_value);
			check_field("present", VAL_W'(want.present), VAL_W'(got.present));
			check_field("lines_held", VAL_W'(want.lines_held), VAL_W'(got.lines_held));
			check_field("status", VAL_W'(want.status), VAL_W'(got.status));
			check_field("last", VAL_W'(want.last), VAL_W'(got.last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ltb_chan_if #(.T(in_word_t))  req_ch ();
	ltb_chan_if #(.T(out_word_t)) rsp_ch ();

	line_table_edit_buffer_core #(
		.MAX_LINES  (MAX_LINES),
		.PRINT_MAX  (PRINT_MAX),
		.HANDLE_BITS(HANDLE_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	line_table_scoreboard sb;
	int unsigned src_idle_pct = 21;
	int unsigned snk_idle_pct = 88;
	int unsigned items_sent   = 0;
	int unsigned quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic in_word_t make_word(logic [1:0] act, int unsigned first,
		int unsigned lastl, logic [VAL_W-1:0] handle);
		in_word_t w;
		w.action     = act;
		w.first_line = LINE_W'(first);
		w.last_line  = LINE_W'(lastl);
		w.row_handle = handle;
		return w;
	endfunction

	// Mostly well-formed edits around the current text, with some noise.
	function automatic in_word_t pick_item();
		in_word_t w;
		int unsigned cnt, roll, sel, first;
		cnt  = sb.line_cnt;
		roll = $urandom_range(99);
		sel  = $urandom_range(99);
		w.row_handle = $urandom();
		w.first_line = LINE_W'($urandom_range(65535));
		w.last_line  = LINE_W'($urandom_range(65535));
		if (roll < 50) begin
			w.action = ACT_WRITE;
			if (sel < 60)
				w.first_line = LINE_W'(cnt + 1);
			else if (sel < 85 && cnt != 0)
				w.first_line = LINE_W'($urandom_range(cnt, 1));
			else if (sel >= 95)
				w.first_line = '0;
		end else if (roll < 67) begin
			w.action = ACT_DELETE;
			if (sel < 75 && cnt != 0) begin
				first = $urandom_range(cnt, 1);
				w.first_line = LINE_W'(first);
				w.last_line  = LINE_W'(first + $urandom_range(2));
			end else if (sel < 85) begin
				w.first_line = '0;
				w.last_line  = LINE_W'($urandom_range(3));
			end
		end else if (roll < 96) begin
			w.action = ACT_PRINT;
			if (sel < 80) begin
				first = $urandom_range(cnt + 2);
				w.first_line = LINE_W'(first);
				w.last_line  = LINE_W'(first + $urandom_range(7));
			end else if (sel < 90) begin
				first = $urandom_range(cnt + 1);
				w.first_line = LINE_W'(first);
				w.last_line  = LINE_W'(first + $urandom_range(100, 60));
			end
		end else begin
			w.action = ACT_NONE;
		end
		return w;
	endfunction

	task automatic send_word(in_word_t w);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.data  <= w;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
		sb.note_request(w);
	endtask

	task automatic set_idle(int unsigned src_pct, int unsigned snk_pct);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
	endtask

	// Receiver: random stalls, plus one long hold-off to back the block up.
	initial begin
		int unsigned hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && items_sent >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_response(rsp_ch.data);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_idle(21, 88);
		send_word(make_word(ACT_PRINT, 1, 1, 32'h0));
		send_word(make_word(ACT_WRITE, 0, 0, 32'h1234_5678));
		send_word(make_word(ACT_WRITE, 5, 0, 32'hFFFF_FFFF));
		send_word(make_word(ACT_WRITE, 1, 0, 32'h0000_0000));
		send_word(make_word(ACT_WRITE, 2, 65535, 32'hA5A5_A5A5));
		send_word(make_word(ACT_WRITE, 65535, 65535, 32'h5A5A_5A5A));
		send_word(make_word(ACT_PRINT, 0, 4, 32'hFFFF_FFFF));
		send_word(make_word(ACT_PRINT, 65535, 65535, 32'h0));
		send_word(make_word(ACT_PRINT, 0, 65535, 32'h0));
		send_word(make_word(ACT_PRINT, 3, 2, 32'h0));
		send_word(make_word(ACT_PRINT, 0, 0, 32'h0));
		send_word(make_word(ACT_DELETE, 3, 1, 32'h0));
		send_word(make_word(ACT_DELETE, 10, 20, 32'h0));
		send_word(make_word(ACT_DELETE, 0, 0, 32'h0));
		send_word(make_word(ACT_DELETE, 0, 1, 32'h0));
		send_word(make_word(ACT_PRINT, 1, 3, 32'h0));
		send_word(make_word(ACT_DELETE, 2, 65535, 32'h0));
		send_word(make_word(ACT_NONE, 65535, 0, 32'hFFFF_FFFF));
		send_word(make_word(ACT_DELETE, 1, 1, 32'h0));
		send_word(make_word(ACT_DELETE, 1, 5, 32'h0));
		send_word(make_word(ACT_WRITE, 1, 0, 32'hC0DE_0001));
		send_word(make_word(ACT_PRINT, 1, 1, 32'h0));

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 3)
				set_idle(88, 21);
			else if (n == 2 * RAND_ITEMS / 3)
				set_idle(0, 0);
			send_word(pick_item());
		end

		// Ranges past the end of the text, then clear the table.
		send_word(make_word(ACT_WRITE, MAX_LINES + 1, 0, 32'hDEAD_0003));
		send_word(make_word(ACT_PRINT, 1, MAX_LINES + 40, 32'h0));
		send_word(make_word(ACT_DELETE, 1, MAX_LINES, 32'h0));
		send_word(make_word(ACT_PRINT, 1, 2, 32'h0));

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.fail_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== line_table_edit_buffer_core.f =====
design/ltb_pkg.sv
design/ltb_chan_if.sv
design/ltb_store.sv
design/ltb_alu.sv
design/line_table_edit_buffer_core.sv
test/line_table_edit_buffer_core_tb.sv
